@@ hdl/atsms_pkg.sv @@
// Shared constants, types and character tables for the SMS command sequencer.
// Used by atsms_ctrl, atsms_datapath and the top level at_command_sms_sequencer.
// Depends on nothing.
package atsms_pkg;

  localparam int NUMBER_DEPTH  = 12;
  localparam int MESSAGE_DEPTH = 32;
  localparam int LINE_DEPTH    = 24;

  localparam int NUM_CNT_W  = $clog2(NUMBER_DEPTH + 1);
  localparam int MSG_CNT_W  = $clog2(MESSAGE_DEPTH + 1);
  localparam int LINE_CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int NUM_ADDR_W = (NUMBER_DEPTH > 1) ? $clog2(NUMBER_DEPTH) : 1;
  localparam int MSG_ADDR_W = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;

  localparam int CMGF_LEN = 10;
  localparam int CMGS_LEN = 8;
  localparam int MAX_A    = (MESSAGE_DEPTH > NUMBER_DEPTH) ? MESSAGE_DEPTH : NUMBER_DEPTH;
  localparam int MAX_SEG  = (MAX_A > CMGF_LEN) ? MAX_A : CMGF_LEN;
  localparam int IDX_W    = $clog2(MAX_SEG + 1);

  localparam int TICK_W = 20;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd5000;

  localparam logic [2:0] OP_LOAD_NUMBER  = 3'd0;
  localparam logic [2:0] OP_LOAD_MESSAGE = 3'd1;
  localparam logic [2:0] OP_START        = 3'd2;
  localparam logic [2:0] OP_MODEM_BYTE   = 3'd3;
  localparam logic [2:0] OP_TICK         = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_CTRL_Z = 8'h1A;

  // Pieces of the outgoing byte stream, in the order they are sent.
  typedef enum logic [3:0] {
    SEG_CMGF,
    SEG_CMGS,
    SEG_QUOTE_OPEN,
    SEG_NUMBER,
    SEG_QUOTE_CLOSE,
    SEG_NUMBER_CR,
    SEG_MESSAGE,
    SEG_MESSAGE_CR,
    SEG_CTRL_Z,
    SEG_DONE,
    SEG_END
  } seg_t;

  typedef struct packed {
    logic             load_num;
    logic             load_msg;
    logic             clear_loads;
    logic             clear_line;
    logic             line_push;
    logic             tick_inc;
    logic             clear_ticks;
    logic             rd_en;
    seg_t             rd_seg;
    logic [IDX_W-1:0] rd_idx;
    logic             push;
    logic             push_tx;
    logic             push_done;
    logic [1:0]       push_status;
    logic             push_last;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_CNT_W-1:0] num_count;
    logic [MSG_CNT_W-1:0] msg_count;
    logic                 overflow;
    logic                 line_empty;
    logic                 is_ok;
    logic                 is_err;
    logic                 is_prompt;
    logic                 timeout_hit;
    logic                 byte_cr;
    logic                 byte_lf;
    logic                 out_room;
  } dp_stat_t;

  function automatic logic [7:0] cmgf_char(input logic [3:0] i);
    case (i)
      4'd0:    return "A";
      4'd1:    return "T";
      4'd2:    return "+";
      4'd3:    return "C";
      4'd4:    return "M";
      4'd5:    return "G";
      4'd6:    return "F";
      4'd7:    return "=";
      4'd8:    return "1";
      4'd9:    return CHAR_CR;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cmgs_char(input logic [2:0] i);
    case (i)
      3'd0:    return "A";
      3'd1:    return "T";
      3'd2:    return "+";
      3'd3:    return "C";
      3'd4:    return "M";
      3'd5:    return "G";
      3'd6:    return "S";
      3'd7:    return "=";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ok_char(input logic i);
    case (i)
      1'b0:    return "O";
      1'b1:    return "K";
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] err_char(input logic [2:0] i);
    case (i)
      3'd0:    return "E";
      3'd1:    return "R";
      3'd2:    return "R";
      3'd3:    return "O";
      3'd4:    return "R";
      default: return 8'h00;
    endcase
  endfunction

endpackage

@@ hdl/atsms_datapath.sv @@
// Datapath of the SMS command sequencer: number and message stores, line matcher,
// tick counter, timeout register, byte read register and the output register.
// Depends on atsms_pkg; driven by atsms_ctrl through dp_cmd_t.
module atsms_datapath
  import atsms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic [7:0]        data_byte,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              done_res,
  output logic [1:0]        status,
  output logic              last
);

  logic [7:0]            number_mem [NUMBER_DEPTH];
  logic [7:0]            message_mem [MESSAGE_DEPTH];
  logic [NUM_CNT_W-1:0]  num_count;
  logic [MSG_CNT_W-1:0]  msg_count;
  logic                  overflow;
  logic [LINE_CNT_W-1:0] line_count;
  logic                  ok_match;
  logic                  err_match;
  logic                  prompt_match;
  logic [TICK_W-1:0]     elapsed;
  logic [TICK_W-1:0]     elapsed_next;
  logic [TICK_W-1:0]     timeout_ticks;
  logic [7:0]            byte_q;
  logic                  num_full;
  logic                  msg_full;
  logic                  line_full;

  assign num_full  = (num_count == NUM_CNT_W'(NUMBER_DEPTH));
  assign msg_full  = (msg_count == MSG_CNT_W'(MESSAGE_DEPTH));
  assign line_full = (line_count == LINE_CNT_W'(LINE_DEPTH));

  // The counter saturates instead of wrapping.
  assign elapsed_next = (elapsed != '1) ? elapsed + 1'b1 : elapsed;

  assign stat.num_count   = num_count;
  assign stat.msg_count   = msg_count;
  assign stat.overflow    = overflow;
  assign stat.line_empty  = (line_count == '0);
  assign stat.is_ok       = ok_match && (line_count == LINE_CNT_W'(2));
  assign stat.is_err      = err_match && (line_count == LINE_CNT_W'(5));
  assign stat.is_prompt   = prompt_match && (line_count == LINE_CNT_W'(1));
  assign stat.timeout_hit = (elapsed_next >= timeout_ticks);
  assign stat.byte_cr     = (data_byte == CHAR_CR);
  assign stat.byte_lf     = (data_byte == CHAR_LF);
  assign stat.out_room    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_num && !num_full) begin
      number_mem[num_count[NUM_ADDR_W-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_msg && !msg_full) begin
      message_mem[msg_count[MSG_ADDR_W-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      case (cmd.rd_seg)
        SEG_CMGF:                        byte_q <= cmgf_char(cmd.rd_idx[3:0]);
        SEG_CMGS:                        byte_q <= cmgs_char(cmd.rd_idx[2:0]);
        SEG_QUOTE_OPEN, SEG_QUOTE_CLOSE: byte_q <= CHAR_QUOTE;
        SEG_NUMBER:     byte_q <= number_mem[cmd.rd_idx[NUM_ADDR_W-1:0]];
        SEG_MESSAGE:    byte_q <= message_mem[cmd.rd_idx[MSG_ADDR_W-1:0]];
        SEG_NUMBER_CR, SEG_MESSAGE_CR:   byte_q <= CHAR_CR;
        SEG_CTRL_Z:                      byte_q <= CHAR_CTRL_Z;
        default:                         byte_q <= 8'h00;
      endcase
    end
  end

  // Each match flag says the line so far is a prefix of its keyword.
  always_ff @(posedge clk) begin
    if (cmd.line_push && !line_full) begin
      ok_match     <= (stat.line_empty || ok_match) && (line_count < LINE_CNT_W'(2))
                      && (data_byte == ok_char(line_count[0]));
      err_match    <= (stat.line_empty || err_match) && (line_count < LINE_CNT_W'(5))
                      && (data_byte == err_char(line_count[2:0]));
      prompt_match <= stat.line_empty && (data_byte == ">");
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_count     <= '0;
      msg_count     <= '0;
      overflow      <= 1'b0;
      line_count    <= '0;
      elapsed       <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        timeout_ticks <= cfg_data;
      end
      if (cmd.clear_loads) begin
        num_count <= '0;
        msg_count <= '0;
        overflow  <= 1'b0;
      end else if (cmd.load_num) begin
        if (num_full) begin
          overflow <= 1'b1;
        end else begin
          num_count <= num_count + 1'b1;
        end
      end else if (cmd.load_msg) begin
        if (msg_full) begin
          overflow <= 1'b1;
        end else begin
          msg_count <= msg_count + 1'b1;
        end
      end
      if (cmd.clear_line) begin
        line_count <= '0;
      end else if (cmd.line_push && !line_full) begin
        line_count <= line_count + 1'b1;
      end
      if (cmd.clear_ticks) begin
        elapsed <= '0;
      end else if (cmd.tick_inc) begin
        elapsed <= elapsed_next;
      end
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      tx_valid <= cmd.push_tx;
      tx_byte  <= byte_q;
      done_res <= cmd.push_done;
      status   <= cmd.push_status;
      last     <= cmd.push_last;
    end
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> stat.out_room)
    else $error("result pushed while the output register is still held");

  a_counts_in_range: assert property (@(posedge clk) disable iff (rst)
    (num_count <= NUM_CNT_W'(NUMBER_DEPTH)) && (msg_count <= MSG_CNT_W'(MESSAGE_DEPTH))
    && (line_count <= LINE_CNT_W'(LINE_DEPTH)))
    else $error("store count beyond its depth");

  a_done_has_no_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tx_valid && done_res))
    else $error("result carries both a byte and a completion");

endmodule

@@ hdl/atsms_ctrl.sv @@
// Controller of the SMS command sequencer: decodes each input item, tracks the
// exchange phase and steps through the outgoing byte segments.
// Depends on atsms_pkg; drives atsms_datapath through dp_cmd_t.
module atsms_ctrl
  import atsms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PUSH} state_t;
  typedef enum logic [2:0] {PH_IDLE, PH_CMGF, PH_CMGS, PH_SMS, PH_END} phase_t;

  state_t           state, state_next;
  phase_t           phase, phase_next;
  seg_t             seg, seg_next, seg_after;
  logic [IDX_W-1:0] idx, idx_next, idx_inc, seg_len;
  logic [1:0]       done_status, done_status_next;
  logic             accept;
  logic             do_advance;
  logic             do_finish;
  logic [1:0]       finish_status;

  function automatic seg_t next_seg(input seg_t s);
    case (s)
      SEG_CMGS:        return SEG_QUOTE_OPEN;
      SEG_QUOTE_OPEN:  return SEG_NUMBER;
      SEG_NUMBER:      return SEG_QUOTE_CLOSE;
      SEG_QUOTE_CLOSE: return SEG_NUMBER_CR;
      SEG_MESSAGE:     return SEG_MESSAGE_CR;
      default:         return SEG_END;
    endcase
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign idx_inc   = idx + 1'b1;
  assign seg_after = next_seg(seg);

  always_comb begin
    case (seg)
      SEG_CMGF:    seg_len = IDX_W'(CMGF_LEN);
      SEG_CMGS:    seg_len = IDX_W'(CMGS_LEN);
      SEG_NUMBER:  seg_len = IDX_W'(stat.num_count);
      SEG_MESSAGE: seg_len = IDX_W'(stat.msg_count);
      SEG_END:     seg_len = '0;
      default:     seg_len = IDX_W'(1);
    endcase
  end

  always_comb begin
    cmd              = '0;
    state_next       = state;
    phase_next       = phase;
    seg_next         = seg;
    idx_next         = idx;
    done_status_next = done_status;
    do_advance       = 1'b0;
    do_finish        = 1'b0;
    finish_status    = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_LOAD_NUMBER: begin
              cmd.load_num = (phase == PH_IDLE);
            end
            OP_LOAD_MESSAGE: begin
              cmd.load_msg = (phase == PH_IDLE);
            end
            OP_START: begin
              if (phase != PH_IDLE) begin
                seg_next         = SEG_DONE;
                idx_next         = '0;
                done_status_next = ST_REJECT;
                state_next       = S_READ;
              end else if (stat.overflow) begin
                do_finish     = 1'b1;
                finish_status = ST_REJECT;
              end else begin
                cmd.clear_line  = 1'b1;
                cmd.clear_ticks = 1'b1;
                phase_next      = PH_CMGF;
                seg_next        = SEG_CMGF;
                idx_next        = '0;
                state_next      = S_READ;
              end
            end
            OP_MODEM_BYTE: begin
              if (phase != PH_IDLE && !stat.byte_lf) begin
                if (!stat.byte_cr) begin
                  cmd.line_push = 1'b1;
                end else if (!stat.line_empty) begin
                  cmd.clear_line = 1'b1;
                  if (stat.is_ok || (!stat.is_err && stat.is_prompt && phase == PH_CMGS)) begin
                    do_advance = 1'b1;
                  end else begin
                    do_finish     = 1'b1;
                    finish_status = ST_ERR;
                  end
                end
              end
            end
            OP_TICK: begin
              if (phase != PH_IDLE) begin
                cmd.tick_inc = 1'b1;
                if (stat.timeout_hit) begin
                  do_finish     = 1'b1;
                  finish_status = ST_TIMEOUT;
                end
              end
            end
            default: begin
            end
          endcase

          if (do_advance) begin
            idx_next = '0;
            case (phase)
              PH_CMGF: begin
                seg_next   = SEG_CMGS;
                phase_next = PH_CMGS;
                state_next = S_READ;
              end
              PH_CMGS: begin
                seg_next   = SEG_MESSAGE;
                phase_next = PH_SMS;
                state_next = S_READ;
              end
              PH_SMS: begin
                seg_next   = SEG_CTRL_Z;
                phase_next = PH_END;
                state_next = S_READ;
              end
              PH_END: begin
                do_finish     = 1'b1;
                finish_status = ST_OK;
              end
              default: begin
              end
            endcase
          end

          // Ending an exchange empties both stores and reports one completion.
          if (do_finish) begin
            cmd.clear_loads  = 1'b1;
            cmd.clear_line   = 1'b1;
            cmd.clear_ticks  = 1'b1;
            phase_next       = PH_IDLE;
            seg_next         = SEG_DONE;
            idx_next         = '0;
            done_status_next = finish_status;
            state_next       = S_READ;
          end
        end
      end

      S_READ: begin
        // An empty number or message segment is skipped.
        if (seg_len == '0) begin
          seg_next = seg_after;
          idx_next = '0;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_seg = seg;
          cmd.rd_idx = idx;
          state_next = S_PUSH;
        end
      end

      S_PUSH: begin
        if (stat.out_room) begin
          cmd.push        = 1'b1;
          cmd.push_tx     = (seg != SEG_DONE);
          cmd.push_done   = (seg == SEG_DONE);
          cmd.push_status = (seg == SEG_DONE) ? done_status : ST_OK;
          cmd.push_last   = (idx_inc == seg_len) && (seg_after == SEG_END);
          if (idx_inc == seg_len) begin
            seg_next   = seg_after;
            idx_next   = '0;
            state_next = (seg_after == SEG_END) ? S_IDLE : S_READ;
          end else begin
            idx_next   = idx_inc;
            state_next = S_READ;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= PH_IDLE;
      seg         <= SEG_END;
      idx         <= '0;
      done_status <= ST_OK;
    end else begin
      state       <= state_next;
      phase       <= phase_next;
      seg         <= seg_next;
      idx         <= idx_next;
      done_status <= done_status_next;
    end
  end

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && cmd.push_last) |=> !in_stall)
    else $error("final result of an item did not release the input");

  a_phase_moves_on_transfer: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(phase))
    else $error("phase changed without an input transfer");

  a_push_has_segment: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (seg != SEG_END) && (idx < seg_len))
    else $error("result pushed outside any segment");

endmodule

@@ hdl/at_command_sms_sequencer.sv @@
// A load, tick or modem byte that causes nothing is taken without leaving idle.
// Each result is read from a store or table into the byte register, then written
// to the output register; each empty number or message segment adds a skip step.
// One item at a time; results go out one by one, each push waiting out out_stall.
// Reset (rst, synchronous) clears phase, counts, flags and the tick counter and
// sets timeout_ticks to 5000; stores need no clearing pass.
module at_command_sms_sequencer
  import atsms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [7:0]        data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              tx_valid,
  output logic [7:0]        tx_byte,
  output logic              done_res,
  output logic [1:0]        status,
  output logic              last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  atsms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .stat     (stat),
    .cmd      (cmd)
  );

  atsms_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .data_byte (data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_valid  (tx_valid),
    .tx_byte   (tx_byte),
    .done_res  (done_res),
    .status    (status),
    .last      (last)
  );

endmodule
